FILE: rtl/h2b64_pkg.sv
// Package: types, character constants and the base64 alphabet for the hex-to-base64 encoder.
`default_nettype none
package h2b64_pkg;

  localparam int unsigned MaxChars = 4;

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiNine  = 8'd57;
  localparam logic [7:0] AsciiLowA  = 8'd97;
  localparam logic [7:0] AsciiLowF  = 8'd102;
  localparam logic [7:0] LowHexBias = 8'd87;
  localparam logic [7:0] UpperBase  = 8'd65;
  localparam logic [7:0] PadChar    = 8'd61;
  localparam logic [7:0] PlusChar   = 8'd43;
  localparam logic [7:0] SlashChar  = 8'd47;

  typedef struct packed {
    logic [2:0]                cnt;
    logic [MaxChars-1:0][7:0]  chars;
    logic                      bad;
    logic                      last;
  } bundle_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] r;
    begin
      if (idx < 6'd26) begin
        r = UpperBase + {2'd0, idx};
      end else if (idx < 6'd52) begin
        r = AsciiLowA + {2'd0, idx} - 8'd26;
      end else if (idx < 6'd62) begin
        r = AsciiZero + {2'd0, idx} - 8'd52;
      end else if (idx == 6'd62) begin
        r = PlusChar;
      end else begin
        r = SlashChar;
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hex_to_base64_stream_encoder.sv
// Top level: hex character stream in, base64 character stream out.
// Takes one ASCII hex digit per cycle while in_tready is high and gives base64 characters
// from the result register. An ordinary digit makes zero or one output character, so
// a steady stream runs at one digit per clock while the output is ready. The last digit
// of a stream can make up to four characters (flush and '=' padding); the result register
// and one holding slot absorb them, so the next digit is still taken, and input then waits
// while those characters drain.
// The rate is set by the single output port, which moves one character per cycle when ready.
`default_nettype none
module hex_to_base64_stream_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] hex_char
  input  wire logic [1:0] in_tuser,   // [0] first_char, [1] odd_length
  input  wire logic       in_tlast,   // last_char
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] b64_char
  output logic [0:0]      out_tuser,  // [0] bad_digit
  output logic            out_tlast   // last_out
);

  logic [3:0] lb_r, lb_nxt;
  logic [1:0] lc_r, lc_nxt;
  logic [1:0] cm_r, cm_nxt;
  logic       bs_r, bs_nxt;

  h2b64_pkg::bundle_t a_r, a_nxt, b_r, b_nxt, new_b;

  logic       in_acc, pop;
  logic [3:0] lb_e, nib;
  logic [1:0] lc_e, cm_e;
  logic       bs_e, bad, flag, emit, flush;
  logic [7:0] acc;
  logic [7:0] data_ch, flush_ch;
  logic [1:0] lc_post;
  logic [3:0] lb_post;
  logic [2:0] npre, npad, ntot;
  logic [1:0] cm_emit;

  assign in_acc = in_tvalid & in_tready;
  assign pop    = out_tvalid & out_tready;

  always_comb begin
    lb_e = lb_r;
    lc_e = lc_r;
    cm_e = cm_r;
    bs_e = bs_r;
    if (in_tuser[0]) begin
      lb_e = 4'd0;
      lc_e = in_tuser[1] ? 2'd2 : 2'd0;
      cm_e = 2'd0;
      bs_e = 1'b0;
    end
    if (lc_e == 2'd3) begin
      lc_e = 2'd0;
    end

    nib = 4'd0;
    bad = 1'b0;
    if (in_tdata >= h2b64_pkg::AsciiZero && in_tdata <= h2b64_pkg::AsciiNine) begin
      nib = 4'(in_tdata - h2b64_pkg::AsciiZero);
    end else if (in_tdata >= h2b64_pkg::AsciiLowA && in_tdata <= h2b64_pkg::AsciiLowF) begin
      nib = 4'(in_tdata - h2b64_pkg::LowHexBias);
    end else begin
      bad = 1'b1;
    end
    flag = bad | ((lc_e != 2'd0) & bs_e);

    acc     = {lb_e, nib};
    emit    = 1'b0;
    data_ch = h2b64_pkg::PadChar;
    lb_post = nib;
    lc_post = 2'd2;
    unique case (lc_e)
      2'd1: begin
        emit    = 1'b1;
        data_ch = h2b64_pkg::b64_char(acc[5:0]);
        lb_post = 4'd0;
        lc_post = 2'd0;
      end
      2'd2: begin
        emit    = 1'b1;
        data_ch = h2b64_pkg::b64_char(acc[7:2]);
        lb_post = {2'd0, acc[1:0]};
        lc_post = 2'd1;
      end
      default: begin
        lb_post = nib;
        lc_post = 2'd2;
      end
    endcase

    flush    = in_tlast & (lc_post != 2'd0);
    flush_ch = (lc_post == 2'd1) ? h2b64_pkg::b64_char({lb_post[1:0], 4'd0})
                                 : h2b64_pkg::b64_char({lb_post, 2'd0});
    npre    = {2'd0, emit} + {2'd0, flush};
    cm_emit = cm_e + npre[1:0];
    npad    = (in_tlast && cm_emit != 2'd0) ? (3'd4 - {1'b0, cm_emit}) : 3'd0;
    ntot    = ((npre + npad) > 3'd4) ? 3'd4 : (npre + npad);

    new_b.chars = {h2b64_pkg::MaxChars{h2b64_pkg::PadChar}};
    if (emit) begin
      new_b.chars[0] = data_ch;
      if (flush) begin
        new_b.chars[1] = flush_ch;
      end
    end else if (flush) begin
      new_b.chars[0] = flush_ch;
    end
    new_b.cnt  = ntot;
    new_b.bad  = flag;
    new_b.last = in_tlast;

    if (in_tlast) begin
      lb_nxt = 4'd0;
      lc_nxt = 2'd0;
      cm_nxt = 2'd0;
      bs_nxt = 1'b0;
    end else begin
      lb_nxt = lb_post;
      lc_nxt = lc_post;
      cm_nxt = cm_emit;
      bs_nxt = bad;
    end
  end

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (pop) begin
      a_nxt.cnt   = a_r.cnt - 3'd1;
      a_nxt.chars = {h2b64_pkg::PadChar, a_r.chars[h2b64_pkg::MaxChars-1:1]};
    end
    if (a_nxt.cnt == 3'd0) begin
      if (b_r.cnt != 3'd0) begin
        a_nxt     = b_r;
        b_nxt     = new_b;
        if (!in_acc) begin
          b_nxt.cnt = 3'd0;
        end
      end else if (in_acc) begin
        a_nxt = new_b;
      end
    end else if (in_acc) begin
      b_nxt = new_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r     <= 4'd0;
      lc_r     <= 2'd0;
      cm_r     <= 2'd0;
      bs_r     <= 1'b0;
      a_r.cnt  <= 3'd0;
      b_r.cnt  <= 3'd0;
    end else begin
      if (in_acc) begin
        lb_r <= lb_nxt;
        lc_r <= lc_nxt;
        cm_r <= cm_nxt;
        bs_r <= bs_nxt;
      end
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign in_tready    = (b_r.cnt == 3'd0);
  assign out_tvalid   = (a_r.cnt != 3'd0);
  assign out_tdata    = a_r.chars[0];
  assign out_tuser[0] = a_r.bad;
  assign out_tlast    = a_r.last & (a_r.cnt == 3'd1);

endmodule
`default_nettype wire

FILE: rtl/h2b64_checker.sv
// Checker: port-level properties of the hex-to-base64 encoder, bound to the top level.
`default_nettype none
module h2b64_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("output not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled request changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == h2b64_pkg::PadChar && !out_tlast
    |=> out_tvalid && out_tdata == h2b64_pkg::PadChar)
    else $error("padding run broken");

  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'd65 && out_tdata <= 8'd90) ||
                   (out_tdata >= 8'd97 && out_tdata <= 8'd122) ||
                   (out_tdata >= 8'd48 && out_tdata <= 8'd57) ||
                   out_tdata == h2b64_pkg::PlusChar || out_tdata == h2b64_pkg::SlashChar ||
                   out_tdata == h2b64_pkg::PadChar)
    else $error("character outside base64 alphabet");

endmodule

bind hex_to_base64_stream_encoder h2b64_checker u_h2b64_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

FILE: sim/hex_to_base64_stream_encoder_tb.sv
// Testbench: hex character requests in, base64 results checked against a local encoder model.
`timescale 1ns / 100ps
module hex_to_base64_stream_encoder_tb;

  localparam int WatchdogLimit = 2000;
  localparam logic [511:0] Base64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] ch;
    logic       bad;
    logic       last;
  } b64_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] hex_char
  logic [1:0] in_tuser;   // [0] first_char, [1] odd_length
  logic       in_tlast;   // last_char
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] b64_char
  logic [0:0] out_tuser;  // [0] bad_digit
  logic       out_tlast;  // last_out

  hex_to_base64_stream_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  b64_result_t pending_chars[$];
  b64_result_t step_buf[h2b64_pkg::MaxChars];
  int          step_n;

  logic [3:0] held_bits;
  logic [1:0] held_pairs;
  logic [1:0] sent_mod4;
  logic       held_bad;

  bit         in_fire;
  bit         out_fire;
  logic [7:0] seen_char;
  logic       seen_bad;
  logic       seen_last;

  bit src_idle;
  bit sink_idle;
  int sink_hold;
  int error_count;
  int mismatch_count;
  int quiet_cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    in_fire   = (in_tvalid === 1'b1) && (in_tready === 1'b1);
    out_fire  = (out_tvalid === 1'b1) && (out_tready === 1'b1);
    seen_char = out_tdata;
    seen_bad  = out_tuser[0];
    seen_last = out_tlast;
  end

  function automatic logic [7:0] alphabet_char(input int idx);
    return Base64Alphabet[8*(63-idx) +: 8];
  endfunction

  function automatic void clear_stream();
    held_bits  = '0;
    held_pairs = '0;
    sent_mod4  = '0;
    held_bad   = 1'b0;
  endfunction

  function automatic void emit_char(input logic [7:0] ch, input logic bad);
    if (step_n < int'(h2b64_pkg::MaxChars)) begin
      step_buf[step_n].ch   = ch;
      step_buf[step_n].bad  = bad;
      step_buf[step_n].last = 1'b0;
      step_n++;
    end
    sent_mod4 = sent_mod4 + 2'd1;
  endfunction

  function automatic void encode_char(input logic [7:0] c, input bit first, input bit odd,
                                      input bit last);
    int  ci;
    int  nib;
    int  acc;
    int  nbits;
    int  shamt;
    bit  bad;
    bit  flag;
    ci     = int'(c);
    nib    = 0;
    bad    = 1'b0;
    step_n = 0;
    if (first) begin
      clear_stream();
      if (odd) begin
        held_pairs = 2'd2;
      end
    end
    if (ci >= int'(h2b64_pkg::AsciiZero) && ci <= int'(h2b64_pkg::AsciiNine)) begin
      nib = ci - int'(h2b64_pkg::AsciiZero);
    end else if (ci >= int'(h2b64_pkg::AsciiLowA) && ci <= int'(h2b64_pkg::AsciiLowF)) begin
      nib = ci - int'(h2b64_pkg::LowHexBias);
    end else begin
      bad = 1'b1;
    end
    if (held_pairs > 2'd2) begin
      held_pairs = 2'd0;
    end
    flag  = bad | ((held_pairs != 2'd0) ? held_bad : 1'b0);
    acc   = (int'(held_bits) << 4) | nib;
    nbits = int'(held_pairs) * 2 + 4;
    if (nbits >= 6) begin
      nbits -= 6;
      emit_char(alphabet_char((acc >> nbits) & 63), flag);
    end
    held_bits  = 4'(acc & ((1 << nbits) - 1));
    held_pairs = 2'(nbits / 2);
    held_bad   = bad;
    if (last) begin
      if (held_pairs != 2'd0) begin
        shamt = 6 - 2 * int'(held_pairs);
        emit_char(alphabet_char((int'(held_bits) << shamt) & 63), flag);
      end
      while (sent_mod4 != 2'd0 && step_n < int'(h2b64_pkg::MaxChars)) begin
        emit_char(h2b64_pkg::PadChar, flag);
      end
      if (step_n > 0) begin
        step_buf[step_n-1].last = 1'b1;
      end
      clear_stream();
    end
    for (int i = 0; i < step_n; i++) begin
      pending_chars.push_back(step_buf[i]);
    end
  endfunction

  function automatic logic [7:0] pick_hex();
    int d;
    d = $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return (d < 10) ? h2b64_pkg::AsciiZero + 8'(d) : h2b64_pkg::AsciiLowA + 8'(d - 10);
  endfunction

  always @(posedge clk) begin : check_results
    b64_result_t want;
    if (rst_n && out_fire) begin
      if (pending_chars.size() == 0) begin
        error_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: char %h bad %b last %b", seen_char, seen_bad, seen_last);
        end
      end else begin
        want = pending_chars.pop_front();
        if (want.ch !== seen_char || want.bad !== seen_bad || want.last !== seen_last) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected char %h bad %b last %b, got char %h bad %b last %b",
                     want.ch, want.bad, want.last, seen_char, seen_bad, seen_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : sink
    int stall;
    int hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        hold      = sink_hold;
        sink_hold = 0;
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = sink_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_fire);
    end
  end

  task automatic send_char(input logic [7:0] c, input bit first, input bit odd, input bit last);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= {odd, first};
    in_tlast  <= last;
    do @(posedge clk); while (!in_fire);
    encode_char(c, first, odd, last);
  endtask

  task automatic send_hex(input string s, input bit odd);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == 0, odd, i == s.len() - 1);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int len;
    bit odd;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 10);
        odd = ($urandom_range(0, 7) == 0) ? 1'($urandom_range(0, 1)) : 1'(len % 2);
        for (int i = 0; i < len; i++) begin
          send_char(pick_hex(), i == 0, (i == 0) ? odd : 1'($urandom_range(0, 1)),
                    i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  task automatic test_directed();
    send_hex("4d616e", 1'b0);
    send_hex("4d61", 1'b0);
    send_hex("4d", 1'b0);
    send_hex("f", 1'b1);
    send_hex("a", 1'b0);
    send_char(8'h00, 1'b1, 1'b0, 1'b0);
    send_char(h2b64_pkg::AsciiNine, 1'b0, 1'b0, 1'b0);
    send_char(8'd71, 1'b0, 1'b0, 1'b0);
    send_char(8'hff, 1'b0, 1'b1, 1'b0);
    send_char(8'd47, 1'b0, 1'b0, 1'b0);
    send_char(8'd58, 1'b0, 1'b0, 1'b0);
    send_char(8'd96, 1'b0, 1'b0, 1'b0);
    send_char(8'd103, 1'b0, 1'b0, 1'b0);
    send_char(h2b64_pkg::UpperBase, 1'b0, 1'b0, 1'b1);
    send_char(h2b64_pkg::AsciiLowA, 1'b0, 1'b1, 1'b0);
    send_char(h2b64_pkg::AsciiLowF, 1'b0, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_streams();
    run_random(160);
    wait_idle();
  endtask

  task automatic test_no_idle();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_random(25);
    wait_idle();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_hold = 300;
    run_random(30);
    wait_idle();
    src_idle  = 1'b1;
  endtask

  task automatic test_drain_pause();
    run_random(6);
    wait_idle();
    run_random(6);
    wait_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    sink_hold      = 0;
    error_count    = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    clear_stream();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_streams();
    test_no_idle();
    test_backpressure();
    test_drain_pause();
    repeat (16) @(posedge clk);
    if (pending_chars.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", pending_chars.size());
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/h2b64_pkg.sv
rtl/hex_to_base64_stream_encoder.sv
rtl/h2b64_checker.sv
sim/hex_to_base64_stream_encoder_tb.sv
